// ===== sv/whcp_pkg.sv =====
`default_nettype none

package whcp_pkg;

	localparam logic [31:0] ID_RIFF = 32'h4646_4952;
	localparam logic [31:0] ID_WAVE = 32'h4556_4157;
	localparam logic [31:0] ID_FMT  = 32'h2074_6D66;
	localparam logic [31:0] ID_DATA = 32'h6174_6164;

	localparam logic [31:0] MIN_FILE_BYTES = 32'd44;
	localparam logic [31:0] FMT_MIN_SIZE   = 32'd16;
	localparam logic [31:0] RIFF_LAST_POS  = 32'd3;
	localparam logic [31:0] FILE_HDR_LAST  = 32'd11;
	localparam logic [15:0] FMT_PCM        = 16'd1;

	// Chunk byte counter: a payload plus its pad byte reaches 2^32
	localparam int          LEFT_W          = 33;
	localparam logic [LEFT_W-1:0] CHUNK_HDR_BYTES = LEFT_W'(8);

	// State of one file as it stands after its final byte
	typedef struct packed {
		logic        hdr_good;
		logic        payload_seen;
		logic [15:0] format;
		logic [15:0] channels;
		logic [31:0] rate;
		logic [15:0] bits;
		logic [31:0] offset;
		logic [31:0] size;
	} snap_t;

endpackage

`default_nettype wire

// ===== sv/wav_header_chunk_parser_core.sv =====
// WAV header checker. Feed the file on the byte channel, one beat per byte
// from offset zero, with last_byte set on the final byte. Each file yields
// exactly one beat on the result channel; other bytes yield nothing.
// Byte channel: byte_valid/byte_ready carrying byte_value and last_byte.
// Result channel: result_valid/result_ready carrying ok, channel_count,
// rate_hz, sample_bits, payload_offset and payload_size; all fields other
// than ok are zero when ok is low.
// Throughput: one byte per cycle while byte_ready is high; the chunk walker
// updates its counters and shift registers as each byte is taken, and
// back-to-back files need no gap. The final byte is captured into a
// snapshot register at its accepting edge; the verdict register loads from
// it when snap_ready is high, and result_valid then rises.
// Stalls: a held result fills the output register, then the snapshot
// register; while the snapshot register is full and cannot drain,
// byte_ready is low for every byte, so the walker holds until it empties.
// Reset (arst_n low) clears the walker to the start of a file and empties
// both registers; the walker is cleared the same way after every final byte.
`default_nettype none

module wav_header_chunk_parser_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        byte_valid,
	output logic             byte_ready,
	input  wire logic [7:0]  byte_value,
	input  wire logic        last_byte,
	output logic             result_valid,
	input  wire logic        result_ready,
	output logic             ok,
	output logic [1:0]       channel_count,
	output logic [31:0]      rate_hz,
	output logic [4:0]       sample_bits,
	output logic [31:0]      payload_offset,
	output logic [31:0]      payload_size
);
	import whcp_pkg::*;

	logic  snap_valid_s1;
	logic  snap_ready;
	snap_t snap_s1;

	whcp_walker u_walker (
		.clk           (clk),
		.arst_n        (arst_n),
		.byte_value    (byte_value),
		.last_byte     (last_byte),
		.byte_valid    (byte_valid),
		.byte_ready    (byte_ready),
		.snap_valid_s1 (snap_valid_s1),
		.snap_s1       (snap_s1),
		.snap_ready    (snap_ready)
	);

	whcp_verdict u_verdict (
		.clk            (clk),
		.arst_n         (arst_n),
		.snap_valid_s1  (snap_valid_s1),
		.snap_s1        (snap_s1),
		.snap_ready     (snap_ready),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.ok             (ok),
		.channel_count  (channel_count),
		.rate_hz        (rate_hz),
		.sample_bits    (sample_bits),
		.payload_offset (payload_offset),
		.payload_size   (payload_size)
	);

endmodule

`default_nettype wire

// ===== sv/whcp_walker.sv =====
`default_nettype none

module whcp_walker (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic [7:0]     byte_value,
	input  wire logic           last_byte,
	input  wire logic           byte_valid,
	output logic                byte_ready,
	output logic                snap_valid_s1,
	output whcp_pkg::snap_t     snap_s1,
	input  wire logic           snap_ready
);
	import whcp_pkg::*;

	typedef enum logic [2:0] {
		PH_FILE = 3'b001,
		PH_HDR  = 3'b010,
		PH_BODY = 3'b100
	} phase_t;

	phase_t              phase_q, phase_d;
	logic [31:0]         pos_q, pos_d;
	logic                hdr_good_q, hdr_good_d;
	logic [63:0]         chb_q, chb_d;
	logic [LEFT_W-1:0]   left_q, left_d;
	logic [63:0]         pend_fmt_q, pend_fmt_d;
	logic [15:0]         pend_bits_q, pend_bits_d;
	logic [31:0]         pend_off_q, pend_off_d;
	logic [15:0]         kept_format_q, kept_format_d;
	logic [15:0]         kept_channels_q, kept_channels_d;
	logic [31:0]         kept_rate_q, kept_rate_d;
	logic [15:0]         kept_bits_q, kept_bits_d;
	logic [31:0]         kept_off_q, kept_off_d;
	logic [31:0]         kept_size_q, kept_size_d;
	logic                seen_q, seen_d;

	logic                take;
	logic [63:0]         hdr_shift;
	logic [LEFT_W-1:0]   left_dec;
	logic [31:0]         id_cur, size_cur, id_new, size_new, commit_size;
	logic [LEFT_W-1:0]   total_cur, body_idx;
	logic                fmt_chunk, commit_fmt, commit_data;
	snap_t               snap_d;

	assign byte_ready = !snap_valid_s1 || snap_ready;
	assign take       = byte_valid && byte_ready;

	always_comb begin
		phase_d         = phase_q;
		hdr_good_d      = hdr_good_q;
		chb_d           = chb_q;
		pend_fmt_d      = pend_fmt_q;
		pend_bits_d     = pend_bits_q;
		pend_off_d      = pend_off_q;
		kept_format_d   = kept_format_q;
		kept_channels_d = kept_channels_q;
		kept_rate_d     = kept_rate_q;
		kept_bits_d     = kept_bits_q;
		kept_off_d      = kept_off_q;
		kept_size_d     = kept_size_q;
		seen_d          = seen_q;

		pos_d     = (pos_q == '1) ? pos_q : pos_q + 32'd1;
		hdr_shift = {byte_value, chb_q[63:8]};
		left_dec  = (left_q != '0) ? left_q - LEFT_W'(1) : left_q;
		left_d    = left_q;

		id_cur    = chb_q[31:0];
		size_cur  = chb_q[63:32];
		total_cur = {1'b0, size_cur} + {{(LEFT_W-1){1'b0}}, size_cur[0]};
		body_idx  = total_cur - left_q;
		fmt_chunk = (id_cur == ID_FMT) && (size_cur >= FMT_MIN_SIZE);
		id_new    = hdr_shift[31:0];
		size_new  = hdr_shift[63:32];

		commit_fmt  = 1'b0;
		commit_data = 1'b0;
		commit_size = size_cur;

		case (phase_q)
			PH_HDR: begin
				chb_d  = hdr_shift;
				left_d = left_dec;
				if (left_dec == '0) begin
					pend_off_d  = pos_d;
					commit_size = size_new;
					// an empty data chunk counts at once
					commit_data = (size_new == '0) && (id_new == ID_DATA);
					if (size_new == '0) begin
						left_d = CHUNK_HDR_BYTES;
					end else begin
						left_d  = {1'b0, size_new} + {{(LEFT_W-1){1'b0}}, size_new[0]};
						phase_d = PH_BODY;
					end
				end
			end
			PH_BODY: begin
				if (fmt_chunk) begin
					if (body_idx[LEFT_W-1:3] == '0) begin
						pend_fmt_d[{body_idx[2:0], 3'b000} +: 8] = byte_value;
					end else if (body_idx == LEFT_W'(14)) begin
						pend_bits_d[7:0] = byte_value;
					end else if (body_idx == LEFT_W'(15)) begin
						pend_bits_d[15:8] = byte_value;
					end
				end
				left_d = left_dec;
				// last payload byte, before any pad byte
				if (size_cur != '0 && body_idx == {1'b0, size_cur} - LEFT_W'(1)) begin
					commit_fmt  = fmt_chunk;
					commit_data = (id_cur == ID_DATA);
				end
				if (left_dec == '0) begin
					phase_d = PH_HDR;
					left_d  = CHUNK_HDR_BYTES;
				end
			end
			PH_FILE: begin
				chb_d = hdr_shift;
				if (pos_q == RIFF_LAST_POS && size_new != ID_RIFF) begin
					hdr_good_d = 1'b0;
				end
				if (pos_q == FILE_HDR_LAST) begin
					if (size_new != ID_WAVE) begin
						hdr_good_d = 1'b0;
					end
					phase_d = PH_HDR;
					left_d  = CHUNK_HDR_BYTES;
				end
			end
			default: begin
				phase_d = PH_FILE;
			end
		endcase

		if (commit_fmt) begin
			kept_format_d   = pend_fmt_d[15:0];
			kept_channels_d = pend_fmt_d[31:16];
			kept_rate_d     = pend_fmt_d[63:32];
			kept_bits_d     = pend_bits_d;
		end
		if (commit_data) begin
			kept_off_d  = pend_off_d;
			kept_size_d = commit_size;
			seen_d      = 1'b1;
		end

		snap_d.hdr_good     = hdr_good_d && (pos_d >= MIN_FILE_BYTES);
		snap_d.payload_seen = seen_d;
		snap_d.format       = kept_format_d;
		snap_d.channels     = kept_channels_d;
		snap_d.rate         = kept_rate_d;
		snap_d.bits         = kept_bits_d;
		snap_d.offset       = kept_off_d;
		snap_d.size         = kept_size_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_FILE;
			pos_q           <= '0;
			hdr_good_q      <= 1'b1;
			chb_q           <= '0;
			left_q          <= '0;
			pend_fmt_q      <= '0;
			pend_bits_q     <= '0;
			pend_off_q      <= '0;
			kept_format_q   <= '0;
			kept_channels_q <= '0;
			kept_rate_q     <= '0;
			kept_bits_q     <= '0;
			kept_off_q      <= '0;
			kept_size_q     <= '0;
			seen_q          <= 1'b0;
		end else if (take) begin
			if (last_byte) begin
				// final byte taken: start a fresh file on the next beat
				phase_q         <= PH_FILE;
				pos_q           <= '0;
				hdr_good_q      <= 1'b1;
				chb_q           <= '0;
				left_q          <= '0;
				pend_fmt_q      <= '0;
				pend_bits_q     <= '0;
				pend_off_q      <= '0;
				kept_format_q   <= '0;
				kept_channels_q <= '0;
				kept_rate_q     <= '0;
				kept_bits_q     <= '0;
				kept_off_q      <= '0;
				kept_size_q     <= '0;
				seen_q          <= 1'b0;
			end else begin
				phase_q         <= phase_d;
				pos_q           <= pos_d;
				hdr_good_q      <= hdr_good_d;
				chb_q           <= chb_d;
				left_q          <= left_d;
				pend_fmt_q      <= pend_fmt_d;
				pend_bits_q     <= pend_bits_d;
				pend_off_q      <= pend_off_d;
				kept_format_q   <= kept_format_d;
				kept_channels_q <= kept_channels_d;
				kept_rate_q     <= kept_rate_d;
				kept_bits_q     <= kept_bits_d;
				kept_off_q      <= kept_off_d;
				kept_size_q     <= kept_size_d;
				seen_q          <= seen_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_valid_s1 <= 1'b0;
		end else if (take && last_byte) begin
			snap_valid_s1 <= 1'b1;
		end else if (snap_ready) begin
			snap_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && last_byte) begin
			snap_s1 <= snap_d;
		end
	end

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		take && last_byte |=> pos_q == '0 && phase_q == PH_FILE && !seen_q)
		else $error("walker state not cleared after final byte");

	a_body_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_BODY |-> left_q != '0)
		else $error("chunk body entered with no bytes left");

	a_snap_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		take && last_byte |=> snap_valid_s1)
		else $error("final byte did not load a snapshot");

endmodule

`default_nettype wire

// ===== sv/whcp_verdict.sv =====
`default_nettype none

module whcp_verdict (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           snap_valid_s1,
	input  wire whcp_pkg::snap_t snap_s1,
	output logic                snap_ready,
	output logic                result_valid,
	input  wire logic           result_ready,
	output logic                ok,
	output logic [1:0]          channel_count,
	output logic [31:0]         rate_hz,
	output logic [4:0]          sample_bits,
	output logic [31:0]         payload_offset,
	output logic [31:0]         payload_size
);
	import whcp_pkg::*;

	logic        result_valid_q;
	logic        ok_q;
	logic [1:0]  channel_count_q;
	logic [31:0] rate_hz_q;
	logic [4:0]  sample_bits_q;
	logic [31:0] payload_offset_q;
	logic [31:0] payload_size_q;

	logic        good, is_two, is_sixteen, pass;
	logic [31:0] frame_mask, trimmed;

	always_comb begin
		is_two     = (snap_s1.channels == 16'd2);
		is_sixteen = (snap_s1.bits == 16'd16);
		good = snap_s1.hdr_good && snap_s1.payload_seen &&
		       (snap_s1.format == FMT_PCM) && (snap_s1.size != '0) &&
		       (snap_s1.rate != '0) &&
		       (snap_s1.channels == 16'd1 || is_two) &&
		       (snap_s1.bits == 16'd8 || is_sixteen);
		// frame stride is 1, 2 or 4 bytes: trim by masking low bits
		frame_mask = {30'd0, is_two && is_sixteen, is_two || is_sixteen};
		trimmed    = snap_s1.size & ~frame_mask;
		pass       = good && (trimmed != '0);
	end

	assign snap_ready = !result_valid_q || result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (snap_ready) begin
			result_valid_q <= snap_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (snap_valid_s1 && snap_ready) begin
			ok_q             <= pass;
			channel_count_q  <= pass ? snap_s1.channels[1:0] : 2'd0;
			rate_hz_q        <= pass ? snap_s1.rate : 32'd0;
			sample_bits_q    <= pass ? snap_s1.bits[4:0] : 5'd0;
			payload_offset_q <= pass ? snap_s1.offset : 32'd0;
			payload_size_q   <= pass ? trimmed : 32'd0;
		end
	end

	assign result_valid   = result_valid_q;
	assign ok             = ok_q;
	assign channel_count  = channel_count_q;
	assign rate_hz        = rate_hz_q;
	assign sample_bits    = sample_bits_q;
	assign payload_offset = payload_offset_q;
	assign payload_size   = payload_size_q;

	a_ok_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && ok |-> (channel_count == 2'd1 || channel_count == 2'd2) &&
		(sample_bits == 5'd8 || sample_bits == 5'd16) && payload_size != '0 && rate_hz != '0)
		else $error("accepted verdict with impossible format fields");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !ok |-> channel_count == '0 && rate_hz == '0 && sample_bits == '0 &&
		payload_offset == '0 && payload_size == '0)
		else $error("rejected verdict carries nonzero fields");

endmodule

`default_nettype wire
